### rtl/rfd_pkg.sv
// Shared constants, payload types and register codes of the resonant feedback delay.
package rfd_pkg;

  localparam int LINE_LENGTH = 4096;
  localparam int LINE_AW     = $clog2(LINE_LENGTH);
  localparam int CHANNELS    = 2;
  localparam int SMP_W       = 24;
  localparam int WORD_W      = 2 * SMP_W;
  localparam int INT_W       = 32;
  localparam int CFG_IW      = 3;
  localparam int CFG_DW      = 24;
  localparam int MUL_W       = 34;
  localparam int PROD_W      = 2 * MUL_W;
  localparam int ACC_W       = 60;
  localparam int DIV_NW      = 50;
  localparam int DIV_DW      = 28;

  typedef enum logic [CFG_IW-1:0] {
    REG_ACTIVE,
    REG_DELAY_WHOLE,
    REG_DELAY_FRACTION,
    REG_SVF_COEF_ONE,
    REG_SVF_COEF_TWO,
    REG_SVF_COEF_THREE,
    REG_LOOP_GAIN
  } cfg_reg_t;

  typedef struct packed {
    logic signed [SMP_W-1:0] left_in;
    logic signed [SMP_W-1:0] right_in;
  } in_t;

  typedef struct packed {
    logic signed [SMP_W-1:0] left_out;
    logic signed [SMP_W-1:0] right_out;
  } out_t;

endpackage

### rtl/rfd_line_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module rfd_line_ram #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 48
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/rfd_mul.sv
// Shared signed multiplier with a registered product.
module rfd_mul (
  input  logic                              clk,
  input  logic signed [rfd_pkg::MUL_W-1:0]  a,
  input  logic signed [rfd_pkg::MUL_W-1:0]  b,
  output logic signed [rfd_pkg::PROD_W-1:0] p_r
);

  always_ff @(posedge clk) begin
    p_r <= a * b;
  end

endmodule

### rtl/rfd_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
module rfd_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [rfd_pkg::DIV_NW-1:0]  dividend,
  input  logic [rfd_pkg::DIV_DW-1:0]  divisor,
  output logic                        done_r,
  output logic [rfd_pkg::DIV_NW-1:0]  quo_r
);

  localparam int NW    = rfd_pkg::DIV_NW;
  localparam int DW    = rfd_pkg::DIV_DW;
  localparam int CNT_W = $clog2(NW + 1);

  logic          busy_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DW-1:0] rem_r;
  logic [DW-1:0] div_r;
  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          ge;
  logic [DW-1:0] rem_nxt;

  always_comb begin
    trial   = {rem_r, quo_r[NW-1]};
    diff    = trial - {1'b0, div_r};
    ge      = trial >= {1'b0, div_r};
    rem_nxt = ge ? diff[DW-1:0] : trial[DW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        rem_r  <= '0;
        quo_r  <= dividend;
        div_r  <= divisor;
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        quo_r <= {quo_r[NW-2:0], ge};
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(NW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

### rtl/resonant_feedback_delay_top.sv
// Top level: stereo fractional delay loop with bandpass, soft limiter and hard clip.
// Inactive: a request is passed to the output without processing. Active: the delay
// line is read once per request, then each channel in turn is interpolated, filtered
// and soft-limited on one shared multiplier; the 50-step tanh divide is skipped when the
// limiter saturates. A request is taken only when the previous result has been output.
// Reset (synchronous, rst_n low) and a write of active from 1 to 0 start a clearing
// pass over all 4096 words of the line memory; no request is taken until it ends.
module resonant_feedback_delay_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  rfd_pkg::in_t                      in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output rfd_pkg::out_t                     out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [rfd_pkg::CFG_IW-1:0]        cfg_index,
  input  logic [rfd_pkg::CFG_DW-1:0]        cfg_data
);

  localparam int SMP_W  = rfd_pkg::SMP_W;
  localparam int INT_W  = rfd_pkg::INT_W;
  localparam int MUL_W  = rfd_pkg::MUL_W;
  localparam int PROD_W = rfd_pkg::PROD_W;
  localparam int ACC_W  = rfd_pkg::ACC_W;
  localparam int AW     = rfd_pkg::LINE_AW;
  localparam int NW     = rfd_pkg::DIV_NW;
  localparam int DW     = rfd_pkg::DIV_DW;

  localparam logic signed [PROD_W-1:0] RND16 = PROD_W'(64'sd32768);
  localparam logic signed [PROD_W-1:0] RND20 = PROD_W'(64'sd524288);
  localparam logic signed [ACC_W-1:0]  RND22 = ACC_W'(64'sd2097152);
  localparam logic signed [ACC_W-1:0]  SAT_HI = ACC_W'(64'sd2147483647);
  localparam logic signed [ACC_W-1:0]  SAT_LO = ACC_W'(-64'sd2147483648);
  localparam logic [31:0]              TANH_SAT = 32'(3 * (1 << 20));
  localparam logic [27:0]              K27 = 28'(27 * (1 << 20));
  localparam logic signed [SMP_W:0]    CLIP_HI = (SMP_W+1)'(4194304);
  localparam logic signed [SMP_W:0]    CLIP_LO = -(SMP_W+1)'(4194304);
  localparam logic signed [MUL_W-1:0]  RECIP3 = MUL_W'(64'sd5726623062);
  localparam logic signed [21:0]       ONE = 22'(1 << 20);

  typedef enum logic [4:0] {
    S_IDLE, S_RD1, S_RD2, S_MINT, S_DELAY, S_V1A, S_V1B, S_V2A, S_V2B, S_GAIN,
    S_ARG, S_ARGW, S_ARGQ, S_SQ, S_SQW, S_NUM, S_NUMW, S_DIVW, S_INJ, S_WR, S_OUT
  } state_t;

  state_t state_r;

  // Configuration
  logic        active_r;
  logic [11:0] dly_whole_r;
  logic [15:0] dly_frac_r;
  logic [23:0] coef1_r, coef2_r, coef3_r;
  logic [15:0] gain_r;

  // Loop state
  logic signed [INT_W-1:0] ic1_r [rfd_pkg::CHANNELS];
  logic signed [INT_W-1:0] ic2_r [rfd_pkg::CHANNELS];
  logic [AW-1:0] wr_idx_r;
  logic          clr_active_r;
  logic [AW-1:0] clr_cnt_r;

  // Item work registers
  rfd_pkg::in_t x_r;
  logic                      ch_r;
  logic [rfd_pkg::WORD_W-1:0] s0w_r, s1w_r;
  logic signed [33:0]        v3_r;
  logic signed [ACC_W-1:0]   acc_r;
  logic signed [INT_W-1:0]   v1_r;
  logic signed [39:0]        v2_r;
  logic [31:0]               arg_n_r;
  logic signed [22:0]        t_r;
  logic [23:0]               t2_r;
  logic [DW-1:0]             den_r;
  logic                      neg_r;
  logic signed [21:0]        tanh_r;
  logic signed [SMP_W-1:0]   y_left_r, y_right_r;
  logic                      out_valid_r;
  rfd_pkg::out_t             out_data_r;

  // Memory and shared units
  logic                       ram_we;
  logic [AW-1:0]              ram_waddr, ram_raddr;
  logic [rfd_pkg::WORD_W-1:0] ram_wdata, ram_rdata;
  logic signed [MUL_W-1:0]    mul_a, mul_b;
  logic signed [PROD_W-1:0]   p_r;
  logic                       div_start, div_done;
  logic [NW-1:0]              div_dividend, div_quo;
  logic [DW-1:0]              div_divisor;

  // Combinational datapath
  logic [AW-1:0]           rd_dist, i0, i1;
  logic [15:0]             q;
  logic signed [SMP_W-1:0] s0c, s1c, xc;
  logic signed [INT_W-1:0] ic1c, ic2c;
  logic signed [24:0]      diff;
  logic signed [PROD_W-1:0] interp, p_mag, t2_full;
  logic signed [25:0]      delayed;
  logic signed [33:0]      v3n;
  logic signed [ACC_W-1:0] p_lo, rsum, v2sum, ic1e, ic2e, ic1sum, ic2sum;
  logic signed [INT_W-1:0] v1n, ic1n, ic2n;
  logic                    p_neg;
  logic [31:0]             arg_q;
  logic signed [23:0]      tanh3, inject;
  logic signed [SMP_W:0]   ysum;
  logic signed [SMP_W-1:0] yclip;

  function automatic logic signed [INT_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] c;
    c = (v > SAT_HI) ? SAT_HI : ((v < SAT_LO) ? SAT_LO : v);
    return c[INT_W-1:0];
  endfunction

  rfd_line_ram #(
    .DEPTH (rfd_pkg::LINE_LENGTH),
    .WIDTH (rfd_pkg::WORD_W)
  ) u_line (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  rfd_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p_r (p_r)
  );

  rfd_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done_r   (div_done),
    .quo_r    (div_quo)
  );

  always_comb begin
    rd_dist = dly_whole_r + AW'(dly_frac_r != 16'd0);
    i0      = wr_idx_r - rd_dist;
    i1      = i0 + AW'(1);
    q       = 16'd0 - dly_frac_r;

    s0c  = ch_r ? s0w_r[2*SMP_W-1:SMP_W] : s0w_r[SMP_W-1:0];
    s1c  = ch_r ? s1w_r[2*SMP_W-1:SMP_W] : s1w_r[SMP_W-1:0];
    xc   = ch_r ? x_r.right_in : x_r.left_in;
    ic1c = ic1_r[ch_r];
    ic2c = ic2_r[ch_r];
    diff = 25'(s1c) - 25'(s0c);

    // Linear interpolation and bandpass input
    interp  = (p_r + RND16) >>> 16;
    delayed = 26'(s0c) + interp[25:0];
    v3n     = 34'(delayed) - 34'(ic2c);

    p_lo  = p_r[ACC_W-1:0];
    rsum  = (acc_r + p_lo + RND22) >>> 22;
    v1n   = sat32(rsum);
    v2sum = ACC_W'(ic2c) + rsum;

    ic1e   = ACC_W'(ic1c);
    ic2e   = ACC_W'(ic2c);
    ic1sum = (ACC_W'(v1_r) <<< 1) - ic1e;
    ic2sum = (ACC_W'(v2_r) <<< 1) - ic2e;
    ic1n   = sat32(ic1sum);
    ic2n   = sat32(ic2sum);

    p_neg   = p_r[PROD_W-1];
    p_mag   = p_neg ? -p_r : p_r;
    t2_full = (p_r + RND20) >>> 20;
    // Quotient by three from the reciprocal product.
    arg_q   = p_r[65:34];

    tanh3  = (24'(tanh_r) <<< 1) + 24'(tanh_r);
    inject = tanh3 >>> 1;
    ysum   = 25'(xc) + 25'(inject);
    if (ysum > CLIP_HI) begin
      yclip = CLIP_HI[SMP_W-1:0];
    end else if (ysum < CLIP_LO) begin
      yclip = CLIP_LO[SMP_W-1:0];
    end else begin
      yclip = ysum[SMP_W-1:0];
    end
  end

  // Shared multiplier operands by step
  always_comb begin
    case (state_r)
      S_MINT: begin
        mul_a = MUL_W'(q);
        mul_b = MUL_W'(diff);
      end
      S_DELAY: begin
        mul_a = MUL_W'(coef1_r);
        mul_b = MUL_W'(ic1c);
      end
      S_V1A: begin
        mul_a = MUL_W'(coef2_r);
        mul_b = v3_r;
      end
      S_V1B: begin
        mul_a = MUL_W'(coef2_r);
        mul_b = MUL_W'(ic1c);
      end
      S_V2A: begin
        mul_a = MUL_W'(coef3_r);
        mul_b = v3_r;
      end
      S_GAIN: begin
        mul_a = MUL_W'(gain_r);
        mul_b = MUL_W'(v1_r);
      end
      S_ARGW: begin
        mul_a = MUL_W'(arg_n_r);
        mul_b = RECIP3;
      end
      S_SQ: begin
        mul_a = MUL_W'(t_r);
        mul_b = MUL_W'(t_r);
      end
      S_NUM: begin
        mul_a = MUL_W'(t_r);
        mul_b = MUL_W'(K27 + 28'(t2_r));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    div_start    = (state_r == S_NUMW);
    div_dividend = p_mag[NW-1:0];
    div_divisor  = den_r;

    ram_raddr = (state_r == S_IDLE) ? i0 : i1;
    if (clr_active_r) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt_r;
      ram_wdata = '0;
    end else begin
      ram_we    = (state_r == S_WR);
      ram_waddr = wr_idx_r;
      ram_wdata = {y_right_r, y_left_r};
    end
  end

  assign in_stall  = (state_r != S_IDLE) || clr_active_r;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      clr_active_r <= 1'b1;
      clr_cnt_r    <= '0;
      wr_idx_r     <= '0;
      ch_r         <= 1'b0;
      active_r     <= 1'b0;
      dly_whole_r  <= 12'd1;
      dly_frac_r   <= '0;
      coef1_r      <= '0;
      coef2_r      <= '0;
      coef3_r      <= '0;
      gain_r       <= '0;
      for (int c = 0; c < rfd_pkg::CHANNELS; c++) begin
        ic1_r[c] <= '0;
        ic2_r[c] <= '0;
      end
    end else begin
      if (out_valid_r && !out_stall && (state_r != S_OUT)) begin
        out_valid_r <= 1'b0;
      end

      if (clr_active_r) begin
        clr_cnt_r <= clr_cnt_r + AW'(1);
        if (clr_cnt_r == AW'(rfd_pkg::LINE_LENGTH - 1)) begin
          clr_active_r <= 1'b0;
        end
      end

      case (state_r)
        S_IDLE: begin
          if (in_valid && !in_stall) begin
            x_r       <= in_data;
            y_left_r  <= in_data.left_in;
            y_right_r <= in_data.right_in;
            ch_r      <= 1'b0;
            state_r   <= active_r ? S_RD1 : S_OUT;
          end
        end
        S_RD1: begin
          s0w_r   <= ram_rdata;
          state_r <= S_RD2;
        end
        S_RD2: begin
          s1w_r   <= ram_rdata;
          state_r <= S_MINT;
        end
        S_MINT: begin
          state_r <= S_DELAY;
        end
        S_DELAY: begin
          v3_r    <= v3n;
          state_r <= S_V1A;
        end
        S_V1A: begin
          acc_r   <= p_lo;
          state_r <= S_V1B;
        end
        S_V1B: begin
          v1_r    <= v1n;
          state_r <= S_V2A;
        end
        S_V2A: begin
          acc_r   <= p_lo;
          state_r <= S_V2B;
        end
        S_V2B: begin
          v2_r        <= v2sum[39:0];
          ic1_r[ch_r] <= ic1n;
          state_r     <= S_GAIN;
        end
        S_GAIN: begin
          ic2_r[ch_r] <= ic2n;
          state_r     <= S_ARG;
        end
        S_ARG: begin
          // The divide by 3 * 2^16 of twice the product is a shift by 15 and a divide by 3.
          neg_r   <= p_neg;
          arg_n_r <= p_mag[46:15];
          state_r <= S_ARGW;
        end
        S_ARGW: begin
          state_r <= S_ARGQ;
        end
        S_ARGQ: begin
          // Beyond three the rational tanh is exactly one.
          if (arg_q >= TANH_SAT) begin
            tanh_r  <= neg_r ? -ONE : ONE;
            state_r <= S_INJ;
          end else begin
            t_r     <= neg_r ? -$signed({1'b0, arg_q[21:0]})
                             : $signed({1'b0, arg_q[21:0]});
            state_r <= S_SQ;
          end
        end
        S_SQ: begin
          state_r <= S_SQW;
        end
        S_SQW: begin
          t2_r    <= t2_full[23:0];
          state_r <= S_NUM;
        end
        S_NUM: begin
          den_r   <= DW'(K27 + 28'(t2_r) + (28'(t2_r) << 3));
          state_r <= S_NUMW;
        end
        S_NUMW: begin
          neg_r   <= p_neg;
          state_r <= S_DIVW;
        end
        S_DIVW: begin
          if (div_done) begin
            tanh_r  <= neg_r ? -$signed(div_quo[21:0]) : $signed(div_quo[21:0]);
            state_r <= S_INJ;
          end
        end
        S_INJ: begin
          if (ch_r) begin
            y_right_r <= yclip;
          end else begin
            y_left_r <= yclip;
          end
          if (ch_r == 1'(rfd_pkg::CHANNELS - 1)) begin
            state_r <= S_WR;
          end else begin
            ch_r    <= ~ch_r;
            state_r <= S_MINT;
          end
        end
        S_WR: begin
          wr_idx_r <= wr_idx_r + AW'(1);
          state_r  <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r          <= 1'b1;
            out_data_r.left_out  <= y_left_r;
            out_data_r.right_out <= y_right_r;
            state_r              <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          rfd_pkg::REG_ACTIVE: begin
            active_r <= cfg_data[0];
            // Turning the loop off clears the lines and integrators.
            if (active_r && !cfg_data[0]) begin
              clr_active_r <= 1'b1;
              clr_cnt_r    <= '0;
              for (int c = 0; c < rfd_pkg::CHANNELS; c++) begin
                ic1_r[c] <= '0;
                ic2_r[c] <= '0;
              end
            end
          end
          rfd_pkg::REG_DELAY_WHOLE:    dly_whole_r <= cfg_data[11:0];
          rfd_pkg::REG_DELAY_FRACTION: dly_frac_r  <= cfg_data[15:0];
          rfd_pkg::REG_SVF_COEF_ONE:   coef1_r     <= cfg_data;
          rfd_pkg::REG_SVF_COEF_TWO:   coef2_r     <= cfg_data;
          rfd_pkg::REG_SVF_COEF_THREE: coef3_r     <= cfg_data;
          rfd_pkg::REG_LOOP_GAIN:      gain_r      <= cfg_data[15:0];
          default: begin
          end
        endcase
      end
    end
  end

endmodule
